[sv/pfde_pkg.sv]
`default_nettype none
package pfde_pkg;

    typedef logic signed [17:0] s18_t;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_HLINE  = 3'd1,
        OP_VLINE  = 3'd2,
        OP_RECT   = 3'd3,
        OP_ORIGIN = 3'd4,
        OP_TEXT   = 3'd5,
        OP_GLYPH  = 3'd6,
        OP_READ   = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SEG,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_LNEXT,
        ST_GRD,
        ST_GROW,
        ST_GPIX,
        ST_GNEXT,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef struct packed {
        logic  horiz;
        s18_t  fixed;
        s18_t  p;
        s18_t  q;
    } seg_t;

    typedef struct packed {
        logic  nonempty;
        s18_t  lo;
        s18_t  hi;
    } clip_t;

endpackage
`default_nettype wire

[sv/page_framebuffer_draw_engine.sv]
// Clear writes every frame byte in turn; a line is drawn segment by segment, each clipped
// pixel read and then written back with its bit set; a glyph is fetched row by row with
// each column tested, and each drawn pixel is read and written back.
// One command is in work at a time; each drawn pixel is a read-modify-write of its frame
// byte. After reset the frame memory is swept to zero, one byte per cycle, before the
// first command is taken.
`default_nettype none
module page_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int FONT_WIDTH    = 5,
    parameter int FONT_HEIGHT   = 7,
    parameter int CHAR_GAP      = 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic signed [15:0] s_coord_a,
    input  wire logic signed [15:0] s_coord_b,
    input  wire logic signed [15:0] s_coord_c,
    input  wire logic signed [15:0] s_coord_d,
    input  wire logic [7:0]         s_char_code,
    input  wire logic [2:0]         s_glyph_row_index,
    input  wire logic [7:0]         s_glyph_row_bits,
    input  wire logic               s_glyph_present,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_read_data,
    output logic                    m_is_read
);
    import pfde_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int CW = (XW > YW) ? XW : YW;

    state_t state_reg, state_next;
    logic [2:0]         op_reg;
    logic signed [15:0] a_reg, b_reg, c_reg, d_reg;
    logic [7:0]         ch_reg;
    logic [1:0]         seg_idx_reg;
    logic               horiz_reg;
    logic [XW-1:0]      pix_x_reg;
    logic [YW-1:0]      pix_y_reg;
    logic [CW-1:0]      end_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [2:0]         row_reg, col_reg;
    logic [7:0]         gbits_reg;
    logic               in_range_reg;
    logic [7:0]         rd_byte_reg;
    logic [15:0]        origin_x_reg, cursor_x_reg, cursor_y_reg;
    logic               gv_reg [256];
    logic               m_valid_reg;
    logic [7:0]         m_read_data_reg;
    logic               m_is_read_reg;

    logic [7:0] glyph_mem [2048];
    logic [7:0] glyph_q;

    logic          fr_we;
    logic [AW-1:0] fr_waddr, fr_raddr, pix_addr;
    logic [7:0]    fr_wdata, frame_q;

    seg_t  seg;
    clip_t clip;
    s18_t  xe, ye, px, py;
    logic  accept, out_free, last_seg, line_end, gpix_ok, gbit;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_is_read   = m_is_read_reg;

    assign pix_addr = AW'(AW'(pix_y_reg >> 3) * AW'(SCREEN_WIDTH)) + AW'(pix_x_reg);

    always_comb begin
        xe = s18_t'(a_reg) + s18_t'(c_reg) - 18'sd1;
        ye = s18_t'(b_reg) + s18_t'(d_reg) - 18'sd1;
        seg.horiz = 1'b1;
        seg.fixed = s18_t'(b_reg);
        seg.p     = s18_t'(a_reg);
        seg.q     = s18_t'(c_reg);
        if (op_reg == OP_VLINE) begin
            seg.horiz = 1'b0;
            seg.fixed = s18_t'(a_reg);
            seg.p     = s18_t'(b_reg);
            seg.q     = s18_t'(c_reg);
        end else if (op_reg == OP_RECT) begin
            case (seg_idx_reg)
                2'd0: begin
                    seg.horiz = 1'b1; seg.fixed = s18_t'(b_reg);
                    seg.p = s18_t'(a_reg); seg.q = xe;
                end
                2'd1: begin
                    seg.horiz = 1'b1; seg.fixed = ye;
                    seg.p = s18_t'(a_reg); seg.q = xe;
                end
                2'd2: begin
                    seg.horiz = 1'b0; seg.fixed = s18_t'(a_reg);
                    seg.p = s18_t'(b_reg); seg.q = ye;
                end
                default: begin
                    seg.horiz = 1'b0; seg.fixed = xe;
                    seg.p = s18_t'(b_reg); seg.q = ye;
                end
            endcase
        end
    end

    pfde_seg_clip #(
        .X_MAX(SCREEN_WIDTH - 1),
        .Y_MAX(SCREEN_HEIGHT - 1)
    ) u_clip (
        .seg  (seg),
        .clip (clip)
    );

    assign last_seg = (op_reg != OP_RECT) || (seg_idx_reg == 2'd3);
    assign line_end = horiz_reg ? (CW'(pix_x_reg) == end_reg) : (CW'(pix_y_reg) == end_reg);
    assign px   = s18_t'(a_reg) + $signed({15'd0, col_reg});
    assign py   = s18_t'(b_reg) + $signed({15'd0, row_reg});
    assign gbit = gbits_reg[3'(FONT_WIDTH - 1) - col_reg];
    assign gpix_ok = gbit && (px >= 18'sd0) && (px < s18_t'(SCREEN_WIDTH))
                     && (py >= 18'sd0) && (py < s18_t'(SCREEN_HEIGHT));

    always_comb begin
        fr_we    = 1'b0;
        fr_waddr = pix_addr;
        fr_wdata = frame_q | (8'd1 << pix_y_reg[2:0]);
        fr_raddr = (state_reg == ST_IDLE) ? s_coord_a[AW-1:0] : pix_addr;
        if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
            fr_we    = 1'b1;
            fr_waddr = clr_cnt_reg;
            fr_wdata = 8'd0;
        end else if (state_reg == ST_PIX_WR) begin
            fr_we = 1'b1;
        end
    end

    pfde_frame_ram #(
        .DEPTH(FRAME_BYTES),
        .AW   (AW)
    ) u_frame (
        .aclk  (aclk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (frame_q)
    );

    always_ff @(posedge aclk) begin
        if (accept && s_operation == OP_GLYPH) begin
            glyph_mem[{s_char_code, s_glyph_row_index}] <= s_glyph_row_bits;
        end
        glyph_q <= glyph_mem[{ch_reg, row_reg}];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                if (clr_cnt_reg == AW'(FRAME_BYTES - 1)) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_HLINE, OP_VLINE: state_next = ST_SEG;
                        OP_RECT: state_next = (s_coord_c > 16'sd0 && s_coord_d > 16'sd0)
                                              ? ST_SEG : ST_DONE;
                        OP_TEXT: state_next = (s_char_code != NEWLINE_CODE
                                               && gv_reg[s_char_code]) ? ST_GRD : ST_DONE;
                        OP_READ: state_next = ST_RDWAIT;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEG: begin
                if (clip.nonempty) begin
                    state_next = ST_PIX_RD;
                end else if (last_seg) begin
                    state_next = ST_DONE;
                end
            end
            ST_PIX_RD: state_next = ST_PIX_WR;
            ST_PIX_WR: state_next = (op_reg == OP_TEXT) ? ST_GNEXT : ST_LNEXT;
            ST_LNEXT: begin
                if (!line_end) begin
                    state_next = ST_PIX_RD;
                end else begin
                    state_next = last_seg ? ST_DONE : ST_SEG;
                end
            end
            ST_GRD: state_next = ST_GROW;
            ST_GROW: state_next = ST_GPIX;
            ST_GPIX: state_next = gpix_ok ? ST_PIX_RD : ST_GNEXT;
            ST_GNEXT: begin
                if (col_reg != 3'(FONT_WIDTH - 1)) begin
                    state_next = ST_GPIX;
                end else begin
                    state_next = (row_reg == 3'(FONT_HEIGHT - 1)) ? ST_DONE : ST_GRD;
                end
            end
            ST_RDWAIT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg     <= '0;
            origin_x_reg    <= '0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            m_valid_reg     <= 1'b0;
            m_read_data_reg <= '0;
            m_is_read_reg   <= 1'b0;
            for (int i = 0; i < 256; i++) begin
                gv_reg[i] <= 1'b0;
            end
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT, ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg       <= s_operation;
                        a_reg        <= s_coord_a;
                        b_reg        <= s_coord_b;
                        c_reg        <= s_coord_c;
                        d_reg        <= s_coord_d;
                        ch_reg       <= s_char_code;
                        seg_idx_reg  <= 2'd0;
                        row_reg      <= 3'd0;
                        col_reg      <= 3'd0;
                        clr_cnt_reg  <= '0;
                        in_range_reg <= (s_coord_a >= 16'sd0)
                                        && (int'(s_coord_a) < FRAME_BYTES);
                        rd_byte_reg  <= 8'd0;
                        case (s_operation)
                            OP_ORIGIN: begin
                                origin_x_reg <= s_coord_a;
                                cursor_x_reg <= s_coord_a;
                                cursor_y_reg <= s_coord_b;
                            end
                            OP_TEXT: begin
                                a_reg <= cursor_x_reg;
                                b_reg <= cursor_y_reg;
                                if (s_char_code == NEWLINE_CODE) begin
                                    cursor_x_reg <= origin_x_reg;
                                    cursor_y_reg <= cursor_y_reg + 16'(FONT_HEIGHT + 1);
                                end else begin
                                    cursor_x_reg <= cursor_x_reg
                                                    + 16'(FONT_WIDTH + CHAR_GAP);
                                end
                            end
                            OP_GLYPH: begin
                                gv_reg[s_char_code] <= s_glyph_present;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SEG: begin
                    horiz_reg <= seg.horiz;
                    end_reg   <= clip.hi[CW-1:0];
                    if (seg.horiz) begin
                        pix_x_reg <= clip.lo[XW-1:0];
                        pix_y_reg <= seg.fixed[YW-1:0];
                    end else begin
                        pix_x_reg <= seg.fixed[XW-1:0];
                        pix_y_reg <= clip.lo[YW-1:0];
                    end
                    if (!clip.nonempty) begin
                        seg_idx_reg <= seg_idx_reg + 2'd1;
                    end
                end
                ST_LNEXT: begin
                    if (!line_end) begin
                        if (horiz_reg) begin
                            pix_x_reg <= pix_x_reg + 1'b1;
                        end else begin
                            pix_y_reg <= pix_y_reg + 1'b1;
                        end
                    end else begin
                        seg_idx_reg <= seg_idx_reg + 2'd1;
                    end
                end
                ST_GROW: begin
                    gbits_reg <= glyph_q;
                end
                ST_GPIX: begin
                    pix_x_reg <= px[XW-1:0];
                    pix_y_reg <= py[YW-1:0];
                end
                ST_GNEXT: begin
                    if (col_reg != 3'(FONT_WIDTH - 1)) begin
                        col_reg <= col_reg + 3'd1;
                    end else begin
                        col_reg <= 3'd0;
                        row_reg <= row_reg + 3'd1;
                    end
                end
                ST_RDWAIT: begin
                    rd_byte_reg <= in_range_reg ? frame_q : 8'd0;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_read_data_reg <= rd_byte_reg;
                        m_is_read_reg   <= (op_reg == OP_READ);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/pfde_seg_clip.sv]
`default_nettype none
module pfde_seg_clip #(
    parameter int X_MAX = 127,
    parameter int Y_MAX = 63
) (
    input  pfde_pkg::seg_t  seg,
    output pfde_pkg::clip_t clip
);
    import pfde_pkg::*;

    s18_t lo;
    s18_t hi;
    s18_t run_max;
    s18_t fix_max;
    logic fix_ok;

    always_comb begin
        lo      = (seg.p < seg.q) ? seg.p : seg.q;
        hi      = (seg.p < seg.q) ? seg.q : seg.p;
        run_max = seg.horiz ? s18_t'(X_MAX) : s18_t'(Y_MAX);
        fix_max = seg.horiz ? s18_t'(Y_MAX) : s18_t'(X_MAX);
        fix_ok  = (seg.fixed >= 18'sd0) && (seg.fixed <= fix_max);
        clip.lo = (lo < 18'sd0) ? 18'sd0 : lo;
        clip.hi = (hi > run_max) ? run_max : hi;
        clip.nonempty = fix_ok && (clip.lo <= clip.hi);
    end

endmodule
`default_nettype wire

[sv/pfde_frame_ram.sv]
`default_nettype none
module pfde_frame_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sv/pfde_checker.sv]
`default_nettype none
module pfde_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [2:0] s_operation,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_read_data,
    input wire logic       m_is_read
);
    import pfde_pkg::*;

    // A held result word keeps its contents until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_is_read))
        else $error("result word changed while stalled");

    // Only read answers carry data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_read |-> m_read_data == 8'd0)
        else $error("non-read result carries data");

    // One command is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command taken while another is in work");

    // A read command never finishes in the cycle after it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_READ |=> !(m_valid && !$past(m_valid)))
        else $error("read answered too early");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operation (s_operation),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_is_read   (m_is_read)
);
`default_nettype wire

[bench/pfde_checker.sv]
`default_nettype none
module pfde_bench_checker
    import pfde_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [2:0]         s_operation,
    input  wire logic signed [15:0] s_coord_a,
    input  wire logic signed [15:0] s_coord_b,
    input  wire logic signed [15:0] s_coord_c,
    input  wire logic signed [15:0] s_coord_d,
    input  wire logic [7:0]         s_char_code,
    input  wire logic [2:0]         s_glyph_row_index,
    input  wire logic [7:0]         s_glyph_row_bits,
    input  wire logic               s_glyph_present,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [7:0]         m_read_data,
    input  wire logic               m_is_read,
    output int                      errors,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 128;
    localparam int SH = 64;
    localparam int FW = 5;
    localparam int FH = 7;
    localparam int GAP = 1;
    localparam int FRAME_BYTES = SW * ((SH + 7) / 8);

    typedef struct packed {
        logic [7:0] read_data;
        logic       is_read;
    } result_t;

    logic [7:0]  frame_mem [FRAME_BYTES];
    logic [7:0]  glyph_mem [2048];
    logic        glyph_ok [256];
    logic [15:0] org_x;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    result_t     results_due [$];

    initial begin
        errors = 0;
        pending = 0;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void paint_pixel(int x, int y);
        if (x >= 0 && x < SW && y >= 0 && y < SH) begin
            frame_mem[(y / 8) * SW + x][y % 8] = 1'b1;
        end
    endfunction

    function automatic void paint_row(int xa, int xb, int y);
        int lo;
        int hi;
        lo = (xa < xb) ? xa : xb;
        hi = (xa < xb) ? xb : xa;
        if (y >= 0 && y < SH) begin
            if (lo < 0) lo = 0;
            if (hi > SW - 1) hi = SW - 1;
            for (int x = lo; x <= hi; x++) paint_pixel(x, y);
        end
    endfunction

    function automatic void paint_column(int x, int ya, int yb);
        int lo;
        int hi;
        lo = (ya < yb) ? ya : yb;
        hi = (ya < yb) ? yb : ya;
        if (x >= 0 && x < SW) begin
            if (lo < 0) lo = 0;
            if (hi > SH - 1) hi = SH - 1;
            for (int y = lo; y <= hi; y++) paint_pixel(x, y);
        end
    endfunction

    function automatic void paint_glyph(int x, int y, logic [7:0] code);
        logic [7:0] bits;
        if (glyph_ok[code]) begin
            for (int r = 0; r < FH; r++) begin
                bits = glyph_mem[{code, 3'(r)}];
                for (int c = 0; c < FW; c++) begin
                    if (bits[FW - 1 - c]) paint_pixel(x + c, y + r);
                end
            end
        end
    endfunction

    function automatic result_t apply_command();
        result_t res;
        int a;
        int b;
        int c;
        int d;
        res = '0;
        a = s_coord_a;
        b = s_coord_b;
        c = s_coord_c;
        d = s_coord_d;
        case (op_t'(s_operation))
            OP_CLEAR: foreach (frame_mem[i]) frame_mem[i] = '0;
            OP_HLINE: paint_row(a, c, b);
            OP_VLINE: paint_column(a, b, c);
            OP_RECT: begin
                if (c > 0 && d > 0) begin
                    paint_row(a, a + c - 1, b);
                    paint_row(a, a + c - 1, b + d - 1);
                    paint_column(a, b, b + d - 1);
                    paint_column(a + c - 1, b, b + d - 1);
                end
            end
            OP_ORIGIN: begin
                org_x = s_coord_a;
                cur_x = s_coord_a;
                cur_y = s_coord_b;
            end
            OP_TEXT: begin
                if (s_char_code == NEWLINE_CODE) begin
                    cur_x = org_x;
                    cur_y = cur_y + 16'(FH + 1);
                end else begin
                    paint_glyph(int'($signed(cur_x)), int'($signed(cur_y)), s_char_code);
                    cur_x = cur_x + 16'(FW + GAP);
                end
            end
            OP_GLYPH: begin
                glyph_mem[{s_char_code, s_glyph_row_index}] = s_glyph_row_bits;
                glyph_ok[s_char_code] = s_glyph_present;
            end
            default: begin
                res.is_read = 1'b1;
                if (a >= 0 && a < FRAME_BYTES) res.read_data = frame_mem[a];
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            foreach (frame_mem[i]) frame_mem[i] = '0;
            foreach (glyph_ok[i]) glyph_ok[i] = 1'b0;
            org_x = '0;
            cur_x = '0;
            cur_y = '0;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result word", 1, 0);
                end else begin
                    want = results_due.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", m_read_data, want.read_data);
                    if (m_is_read !== want.is_read)
                        report_mismatch("is_read", m_is_read, want.is_read);
                end
            end
            if (s_valid && s_ready) results_due.push_back(apply_command());
        end
        pending = results_due.size();
    end
endmodule
`default_nettype wire

[bench/tb_page_framebuffer_draw_engine.sv]
`default_nettype none
module tb_page_framebuffer_draw_engine;
    import pfde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_operation = '0;
    logic signed [15:0] s_coord_a = '0;
    logic signed [15:0] s_coord_b = '0;
    logic signed [15:0] s_coord_c = '0;
    logic signed [15:0] s_coord_d = '0;
    logic [7:0]         s_char_code = '0;
    logic [2:0]         s_glyph_row_index = '0;
    logic [7:0]         s_glyph_row_bits = '0;
    logic               s_glyph_present = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_read_data;
    logic               m_is_read;
    int                 errors;
    int                 pending;

    int         send_idle_pct = 9;
    int         recv_stall_pct = 54;
    logic       glyph_marked [256];
    logic [7:0] rows_loaded [256];

    page_framebuffer_draw_engine dut (.*);
    pfde_bench_checker u_checker (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("page_framebuffer_draw_engine regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // A text word never draws a marked glyph whose rows are not all loaded.
    task automatic send_word(op_t op, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d, logic [7:0] ch, logic [2:0] ri,
                             logic [7:0] rb, logic gp);
        if (op == OP_TEXT && ch != NEWLINE_CODE && glyph_marked[ch]
                && rows_loaded[ch][6:0] != 7'h7f) begin
            ch = NEWLINE_CODE;
        end
        if (op == OP_GLYPH) begin
            rows_loaded[ch][ri] = 1'b1;
            glyph_marked[ch] = gp;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_coord_a <= a;
        s_coord_b <= b;
        s_coord_c <= c;
        s_coord_d <= d;
        s_char_code <= ch;
        s_glyph_row_index <= ri;
        s_glyph_row_bits <= rb;
        s_glyph_present <= gp;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic send_simple(op_t op, int a, int b, int c, int d, int ch);
        send_word(op, 16'(a), 16'(b), 16'(c), 16'(d), 8'(ch), 3'($urandom),
                  8'($urandom), 1'($urandom));
    endtask

    task automatic load_glyph(logic [7:0] ch);
        for (int r = 0; r < 8; r++)
            send_word(OP_GLYPH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      ch, 3'(r), 8'($urandom), 1'b1);
    endtask

    function automatic logic [15:0] pick_coord(int lo, int hi);
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    initial begin
        int pick;
        logic [7:0] ch;
        foreach (glyph_marked[i]) glyph_marked[i] = 1'b0;
        foreach (rows_loaded[i]) rows_loaded[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_simple(OP_READ, 0, 0, 0, 0, 0);
        send_simple(OP_HLINE, 100, 5, 3, 0, 0);
        send_simple(OP_HLINE, -32768, 63, 32767, 0, 0);
        send_simple(OP_HLINE, 0, -1, 127, 0, 0);
        send_simple(OP_VLINE, 127, -10, 80, 0, 0);
        send_simple(OP_VLINE, 128, 0, 63, 0, 0);
        send_simple(OP_RECT, 120, 60, 20, 20, 0);
        send_simple(OP_RECT, 10, 10, 0, 5, 0);
        send_simple(OP_RECT, 10, 10, 5, -5, 0);
        send_simple(OP_RECT, 32767, 32767, 32767, 32767, 0);
        send_simple(OP_READ, -1, 0, 0, 0, 0);
        send_simple(OP_READ, 1023, 0, 0, 0, 0);
        send_simple(OP_READ, 1024, 0, 0, 0, 0);
        send_simple(OP_READ, -32768, 0, 0, 0, 0);
        send_simple(OP_READ, 32767, 0, 0, 0, 0);
        load_glyph(8'd65);
        send_word(OP_GLYPH, 0, 0, 0, 0, 8'd255, 3'd7, 8'hff, 1'b0);
        send_simple(OP_ORIGIN, -3, -2, 0, 0, 0);
        send_simple(OP_TEXT, 0, 0, 0, 0, 65);
        send_simple(OP_TEXT, 0, 0, 0, 0, 10);
        send_simple(OP_TEXT, 0, 0, 0, 0, 66);
        send_simple(OP_ORIGIN, 32765, 0, 0, 0, 0);
        send_simple(OP_TEXT, 0, 0, 0, 0, 65);
        send_simple(OP_TEXT, 0, 0, 0, 0, 65);
        send_simple(OP_READ, 0, 0, 0, 0, 0);
        send_simple(OP_CLEAR, 0, 0, 0, 0, 0);

        for (int i = 0; i < 350; i++) begin
            if (i == 117) begin
                send_idle_pct = 54;
                recv_stall_pct = 9;
            end else if (i == 234) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (i == 175) wait_drained();
            pick = $urandom_range(0, 99);
            ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(60, 70));
            if (pick < 2) begin
                send_simple(OP_CLEAR, 0, 0, 0, 0, 0);
            end else if (pick < 14) begin
                send_word(OP_HLINE, pick_coord(-20, 150), pick_coord(-5, 70),
                          pick_coord(-20, 150), 16'($urandom), ch, 3'($urandom),
                          8'($urandom), 1'($urandom));
            end else if (pick < 26) begin
                send_word(OP_VLINE, pick_coord(-5, 132), pick_coord(-20, 80),
                          pick_coord(-20, 80), 16'($urandom), ch, 3'($urandom),
                          8'($urandom), 1'($urandom));
            end else if (pick < 36) begin
                send_word(OP_RECT, pick_coord(-20, 140), pick_coord(-20, 70),
                          pick_coord(-3, 40), pick_coord(-3, 30), ch, 3'($urandom),
                          8'($urandom), 1'($urandom));
            end else if (pick < 42) begin
                send_word(OP_ORIGIN, pick_coord(-10, 130), pick_coord(-10, 70),
                          16'($urandom), 16'($urandom), ch, 3'($urandom),
                          8'($urandom), 1'($urandom));
            end else if (pick < 64) begin
                if ($urandom_range(0, 5) == 0) ch = NEWLINE_CODE;
                send_word(OP_TEXT, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), ch, 3'($urandom), 8'($urandom), 1'($urandom));
            end else if (pick < 70) begin
                load_glyph(ch);
            end else if (pick < 74) begin
                send_word(OP_GLYPH, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), ch, 3'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                send_word(OP_READ, pick_coord(-4, 1027), 16'($urandom), 16'($urandom),
                          16'($urandom), ch, 3'($urandom), 8'($urandom), 1'($urandom));
            end
        end

        wait_drained();
        repeat (2000) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("page_framebuffer_draw_engine regression: pass");
        end else begin
            $display("page_framebuffer_draw_engine regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
